// ----- sv/kwm_pkg.sv -----
`timescale 1ns / 1ps

package kwm_pkg;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_START = 2'd1,
      ACT_POP   = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_POP_TOP,
      ST_POP_REPL,
      ST_DN_L,
      ST_DN_R,
      ST_DN_CMP,
      ST_FIN
   } state_type;

   localparam int RUN_ID_W = 4;
   localparam int FIELD_W  = 32;

endpackage

// ----- sv/kwm_if.sv -----
`timescale 1ns / 1ps

interface kwm_req_if;
   logic                          valid;
   logic                          ready;
   kwm_pkg::action_type           action;
   logic [kwm_pkg::RUN_ID_W-1:0]  run_id;
   logic [kwm_pkg::FIELD_W-1:0]   sort_key;
   logic [kwm_pkg::FIELD_W-1:0]   payload;

   modport source (output valid, action, run_id, sort_key, payload, input ready);
   modport sink   (input valid, action, run_id, sort_key, payload, output ready);
endinterface

interface kwm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kwm_pkg::FIELD_W-1:0]   out_key;
   logic [kwm_pkg::FIELD_W-1:0]   out_payload;
   logic [kwm_pkg::RUN_ID_W-1:0]  out_run;
   logic                          valid_res;
   logic                          last;
   logic                          overflow;

   modport source (output valid, out_key, out_payload, out_run, valid_res, last, overflow,
                   input ready);
   modport sink   (input valid, out_key, out_payload, out_run, valid_res, last, overflow,
                   output ready);
endinterface

// ----- sv/kway_heap_merge.sv -----
`timescale 1ns / 1ps
// Load: accepted in ST_IDLE, result registered in ST_FIN once the response slot is free; clear gives no result.
// Pop: each heap level costs a left read, a right read and a compare/write on the heap memory,
// which has one read port and one write port. An empty pop goes straight to ST_FIN, valid_res low.
// Start: scans every run, fetches each non-empty run's head and sifts it up; no result.
// Synchronous active-high reset empties all runs and the heap; memories are not cleared.
module kway_heap_merge #(
   parameter int RUNS         = 16,
   parameter int RUN_DEPTH    = 1024,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   kwm_req_if.sink      req_chan,
   kwm_rsp_if.source    rsp_chan
);

   localparam int RUN_W   = $clog2(RUNS);
   localparam int CNT_W   = RUN_W + 1;
   localparam int IDX_W   = RUN_W + 2;
   localparam int LEN_W   = $clog2(RUN_DEPTH + 1);
   localparam int ADDR_W  = $clog2(RUNS * RUN_DEPTH);
   localparam int SE_W    = KEY_BITS + PAYLOAD_BITS;
   localparam int HE_W    = SE_W + RUN_W;

   typedef logic [HE_W-1:0] hent_type;

   kwm_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0]  len_ff [RUNS];
   logic [LEN_W-1:0]  len_in [RUNS];
   logic [LEN_W-1:0]  cur_ff [RUNS];
   logic [LEN_W-1:0]  cur_in [RUNS];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [RUN_W-1:0]  pos_ff, pos_in;
   hent_type          ent_ff, ent_in;
   hent_type          lch_ff, lch_in;
   hent_type          top_ff, top_in;
   logic              has_r_ff, has_r_in;
   logic              repl_st_ff, repl_st_in;
   logic              res_valid_ff, res_valid_in;
   logic              ovf_ff, ovf_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kwm_pkg::FIELD_W-1:0]  rsp_key_ff, rsp_key_in;
   logic [kwm_pkg::FIELD_W-1:0]  rsp_pay_ff, rsp_pay_in;
   logic [kwm_pkg::RUN_ID_W-1:0] rsp_run_ff, rsp_run_in;
   logic                         rsp_vres_ff, rsp_vres_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic              st_we;
   logic [ADDR_W-1:0] st_waddr, st_raddr;
   logic [SE_W-1:0]   st_wdata, st_rdata;
   logic              hp_we;
   logic [RUN_W-1:0]  hp_waddr, hp_raddr;
   hent_type          hp_wdata, hp_rdata;

   function automatic logic [ADDR_W-1:0] st_addr(input logic [RUN_W-1:0] run,
                                                 input logic [LEN_W-1:0] p);
      st_addr = ADDR_W'(ADDR_W'(run) * ADDR_W'(RUN_DEPTH) + ADDR_W'(p));
   endfunction

   // Order by key, then by run so equal keys leave from the lower run first.
   function automatic logic ent_less(input hent_type a, input hent_type b);
      logic [KEY_BITS-1:0] ka;
      logic [KEY_BITS-1:0] kb;
      ka = a[HE_W-1 -: KEY_BITS];
      kb = b[HE_W-1 -: KEY_BITS];
      ent_less = (ka < kb) || ((ka == kb) && (a[RUN_W-1:0] < b[RUN_W-1:0]));
   endfunction

   logic              accept;
   logic              load_bad;
   logic [RUN_W-1:0]  req_run;
   logic [RUN_W-1:0]  scan_run;
   logic [RUN_W-1:0]  top_run;
   logic [RUN_W-1:0]  parent;
   logic [IDX_W-1:0]  lidx, ridx;
   logic              scan_done, scan_nonempty, top_refill;
   logic              up_lt, dn_l_lt, dn_r_lt, dn_take_r, l_exists;
   logic              rsp_free;

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_run       = RUN_W'(req_chan.run_id);
   assign load_bad      = (int'(req_chan.run_id) >= RUNS) || (len_ff[req_run] == LEN_W'(RUN_DEPTH));
   assign scan_run      = idx_ff[RUN_W-1:0];
   assign scan_done     = (idx_ff == CNT_W'(RUNS));
   assign scan_nonempty = (len_ff[scan_run] != '0);
   assign top_run       = hp_rdata[RUN_W-1:0];
   assign top_refill    = (cur_ff[top_run] < len_ff[top_run]);
   assign parent        = RUN_W'((pos_ff - 1'b1) >> 1);
   assign lidx          = IDX_W'(IDX_W'(pos_ff) * 2 + 1);
   assign ridx          = IDX_W'(lidx + 1'b1);
   assign l_exists      = (lidx < IDX_W'(cnt_ff));
   assign up_lt         = ent_less(ent_ff, hp_rdata);
   assign dn_l_lt       = ent_less(lch_ff, ent_ff);
   assign dn_r_lt       = ent_less(hp_rdata, dn_l_lt ? lch_ff : ent_ff);
   assign dn_take_r     = has_r_ff && dn_r_lt;
   assign rsp_free      = !rsp_valid_ff || rsp_chan.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_chan.action)
                  kwm_pkg::ACT_LOAD:  state_in = kwm_pkg::ST_FIN;
                  kwm_pkg::ACT_START: state_in = kwm_pkg::ST_SCAN;
                  kwm_pkg::ACT_POP:   state_in = (cnt_ff != '0) ? kwm_pkg::ST_POP_TOP
                                                                : kwm_pkg::ST_FIN;
                  default:            state_in = kwm_pkg::ST_IDLE;
               endcase
            end
         end
         kwm_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = kwm_pkg::ST_IDLE;
            end else if (scan_nonempty) begin
               state_in = kwm_pkg::ST_FETCH;
            end
         end
         kwm_pkg::ST_FETCH:    state_in = kwm_pkg::ST_UP_CHK;
         kwm_pkg::ST_UP_CHK:   state_in = (pos_ff == '0) ? kwm_pkg::ST_SCAN : kwm_pkg::ST_UP_CMP;
         kwm_pkg::ST_UP_CMP:   state_in = up_lt ? kwm_pkg::ST_UP_CHK : kwm_pkg::ST_SCAN;
         kwm_pkg::ST_POP_TOP:  state_in = kwm_pkg::ST_POP_REPL;
         kwm_pkg::ST_POP_REPL: state_in = kwm_pkg::ST_DN_L;
         kwm_pkg::ST_DN_L:     state_in = l_exists ? kwm_pkg::ST_DN_R : kwm_pkg::ST_FIN;
         kwm_pkg::ST_DN_R:     state_in = kwm_pkg::ST_DN_CMP;
         kwm_pkg::ST_DN_CMP:   state_in = (dn_take_r || dn_l_lt) ? kwm_pkg::ST_DN_L
                                                                 : kwm_pkg::ST_FIN;
         kwm_pkg::ST_FIN:      state_in = rsp_free ? kwm_pkg::ST_IDLE : kwm_pkg::ST_FIN;
         default:              state_in = kwm_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      len_in       = len_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      ent_in       = ent_ff;
      lch_in       = lch_ff;
      top_in       = top_ff;
      has_r_in     = has_r_ff;
      repl_st_in   = repl_st_ff;
      res_valid_in = res_valid_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_key_in   = rsp_key_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_vres_in  = rsp_vres_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      req_chan.ready = 1'b0;
      st_we    = 1'b0;
      st_waddr = st_addr(req_run, len_ff[req_run]);
      st_wdata = {KEY_BITS'(req_chan.sort_key), PAYLOAD_BITS'(req_chan.payload)};
      st_raddr = '0;
      hp_we    = 1'b0;
      hp_waddr = pos_ff;
      hp_wdata = ent_ff;
      hp_raddr = '0;

      case (state_ff)
         kwm_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               case (req_chan.action)
                  kwm_pkg::ACT_LOAD: begin
                     res_valid_in = 1'b0;
                     ovf_in       = load_bad;
                     if (!load_bad) begin
                        st_we            = 1'b1;
                        len_in[req_run]  = len_ff[req_run] + 1'b1;
                     end
                  end
                  kwm_pkg::ACT_START: begin
                     for (int i = 0; i < RUNS; i++) begin
                        cur_in[i] = '0;
                     end
                     cnt_in = '0;
                     idx_in = '0;
                  end
                  kwm_pkg::ACT_POP: begin
                     res_valid_in = (cnt_ff != '0);
                     ovf_in       = 1'b0;
                     hp_raddr     = '0;
                  end
                  default: begin
                     for (int i = 0; i < RUNS; i++) begin
                        cur_in[i] = '0;
                        len_in[i] = '0;
                     end
                     cnt_in = '0;
                  end
               endcase
            end
         end
         kwm_pkg::ST_SCAN: begin
            st_raddr = st_addr(scan_run, '0);
            if (!scan_done && !scan_nonempty) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         kwm_pkg::ST_FETCH: begin
            ent_in           = {st_rdata, scan_run};
            cur_in[scan_run] = LEN_W'(1);
            pos_in           = cnt_ff[RUN_W-1:0];
            cnt_in           = cnt_ff + 1'b1;
         end
         kwm_pkg::ST_UP_CHK: begin
            hp_raddr = parent;
            if (pos_ff == '0) begin
               hp_we  = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         kwm_pkg::ST_UP_CMP: begin
            hp_we = 1'b1;
            if (up_lt) begin
               hp_wdata = hp_rdata;
               pos_in   = parent;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         kwm_pkg::ST_POP_TOP: begin
            top_in     = hp_rdata;
            repl_st_in = top_refill;
            if (top_refill) begin
               st_raddr        = st_addr(top_run, cur_ff[top_run]);
               cur_in[top_run] = cur_ff[top_run] + 1'b1;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               hp_raddr = RUN_W'(cnt_ff - 1'b1);
            end
         end
         kwm_pkg::ST_POP_REPL: begin
            ent_in = repl_st_ff ? {st_rdata, top_ff[RUN_W-1:0]} : hp_rdata;
            pos_in = '0;
         end
         kwm_pkg::ST_DN_L: begin
            hp_raddr = lidx[RUN_W-1:0];
            if (!l_exists) begin
               hp_we = 1'b1;
            end
         end
         kwm_pkg::ST_DN_R: begin
            lch_in   = hp_rdata;
            has_r_in = (ridx < IDX_W'(cnt_ff));
            hp_raddr = ridx[RUN_W-1:0];
         end
         kwm_pkg::ST_DN_CMP: begin
            hp_we = 1'b1;
            if (dn_take_r) begin
               hp_wdata = hp_rdata;
               pos_in   = ridx[RUN_W-1:0];
            end else if (dn_l_lt) begin
               hp_wdata = lch_ff;
               pos_in   = lidx[RUN_W-1:0];
            end
         end
         kwm_pkg::ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_vres_in  = res_valid_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = res_valid_ff && (cnt_ff == '0);
               rsp_key_in   = res_valid_ff ? kwm_pkg::FIELD_W'(top_ff[HE_W-1 -: KEY_BITS]) : '0;
               rsp_pay_in   = res_valid_ff ?
                              kwm_pkg::FIELD_W'(top_ff[RUN_W +: PAYLOAD_BITS]) : '0;
               rsp_run_in   = res_valid_ff ? kwm_pkg::RUN_ID_W'(top_ff[RUN_W-1:0]) : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwm_pkg::ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < RUNS; i++) begin
            len_ff[i] <= '0;
            cur_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         cur_ff       <= cur_in;
      end
      pos_ff       <= pos_in;
      ent_ff       <= ent_in;
      lch_ff       <= lch_in;
      top_ff       <= top_in;
      has_r_ff     <= has_r_in;
      repl_st_ff   <= repl_st_in;
      res_valid_ff <= res_valid_in;
      ovf_ff       <= ovf_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_vres_ff  <= rsp_vres_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   kwm_ram #(.WIDTH(SE_W), .DEPTH(RUNS * RUN_DEPTH)) u_run_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   kwm_ram #(.WIDTH(HE_W), .DEPTH(RUNS)) u_heap (
      .clock   (clock),
      .wr_en   (hp_we),
      .wr_addr (hp_waddr),
      .wr_data (hp_wdata),
      .rd_addr (hp_raddr),
      .rd_data (hp_rdata)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_key     = rsp_key_ff;
   assign rsp_chan.out_payload = rsp_pay_ff;
   assign rsp_chan.out_run     = rsp_run_ff;
   assign rsp_chan.valid_res   = rsp_vres_ff;
   assign rsp_chan.last        = rsp_last_ff;
   assign rsp_chan.overflow    = rsp_ovf_ff;

endmodule

// ----- sv/kwm_ram.sv -----
`timescale 1ns / 1ps

module kwm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/kwm_checker.sv -----
`timescale 1ns / 1ps

module kwm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] out_key,
   input logic [31:0] out_payload,
   input logic [3:0]  out_run,
   input logic        valid_res,
   input logic        last,
   input logic        overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !valid_res |-> out_key == '0 && out_payload == '0 && out_run == '0 && !last)
      else $error("response without element carries nonzero fields");

   a_ovf_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow |-> !valid_res && !last)
      else $error("overflow flagged on an element response");

endmodule

bind kway_heap_merge kwm_checker u_kwm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_key     (rsp_chan.out_key),
   .out_payload (rsp_chan.out_payload),
   .out_run     (rsp_chan.out_run),
   .valid_res   (rsp_chan.valid_res),
   .last        (rsp_chan.last),
   .overflow    (rsp_chan.overflow)
);

// ----- dv/kwm_tb_if.sv -----
`timescale 1ns / 1ps

// The block's own interfaces live in the RTL tree; nothing extra is needed here.
package kwm_tb_types;

   typedef struct packed {
      logic [kwm_pkg::FIELD_W-1:0]  key;
      logic [kwm_pkg::FIELD_W-1:0]  pay;
      logic [kwm_pkg::RUN_ID_W-1:0] run;
      logic                         vld;
      logic                         last;
      logic                         ovf;
   } merge_out_type;
endpackage

// ----- dv/kway_heap_merge_tb.sv -----
`timescale 1ns / 1ps

module kway_heap_merge_tb;

   localparam int NRUNS = 16;
   localparam int DEPTH = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int FIELD_W = kwm_pkg::FIELD_W;
   localparam int RUN_ID_W = kwm_pkg::RUN_ID_W;

   typedef kwm_tb_types::merge_out_type merge_out_type;

   typedef struct {
      logic [FIELD_W-1:0]  key;
      logic [FIELD_W-1:0]  pay;
      logic [RUN_ID_W-1:0] run;
   } slot_type;

   typedef struct {
      kwm_pkg::action_type act;
      logic [RUN_ID_W-1:0] rid;
      logic [FIELD_W-1:0]  key;
      logic [FIELD_W-1:0]  pay;
      logic                has_exp;
      merge_out_type       exp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kwm_req_if req_chan ();
   kwm_rsp_if rsp_chan ();

   kway_heap_merge dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state for the merge.
   logic [FIELD_W-1:0] run_keys [NRUNS][DEPTH];
   logic [FIELD_W-1:0] run_pays [NRUNS][DEPTH];
   int unsigned run_len [NRUNS];
   int unsigned run_pos [NRUNS];
   slot_type heap [NRUNS];
   int unsigned heap_n;

   merge_out_type pending_out [$];
   stim_row_type rows [$];
   int errors = 0;
   int n_results = 0;
   int n_valid_pops = 0;
   int n_ovf = 0;
   longint cycles = 0;
   logic hold_off = 1'b0;

   function automatic void expect_result(merge_out_type o);
      pending_out = {pending_out, o};
   endfunction

   function automatic void add_row(kwm_pkg::action_type act, logic [RUN_ID_W-1:0] rid,
                                   logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] pay,
                                   logic has_exp, merge_out_type exp);
      stim_row_type r;
      r = '{act, rid, key, pay, has_exp, exp};
      rows = {rows, r};
   endfunction

   function automatic bit slot_less(slot_type a, slot_type b);
      if (a.key != b.key) return a.key < b.key;
      return a.run < b.run;
   endfunction

   function automatic slot_type take_head(int r);
      slot_type s;
      s.key = run_keys[r][run_pos[r]];
      s.pay = run_pays[r][run_pos[r]];
      s.run = r[RUN_ID_W-1:0];
      run_pos[r]++;
      return s;
   endfunction

   function automatic void heap_up(int i);
      slot_type t;
      int p;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!slot_less(heap[i], heap[p])) break;
         t = heap[i]; heap[i] = heap[p]; heap[p] = t;
         i = p;
      end
   endfunction

   function automatic void heap_down(int i);
      slot_type t;
      int l, r, m;
      forever begin
         l = 2 * i + 1; r = l + 1; m = i;
         if (l < heap_n && slot_less(heap[l], heap[m])) m = l;
         if (r < heap_n && slot_less(heap[r], heap[m])) m = r;
         if (m == i) break;
         t = heap[i]; heap[i] = heap[m]; heap[m] = t;
         i = m;
      end
   endfunction

   // Applies one request to the predictor; returns 1 and fills o when a result follows.
   function automatic bit merge_predict(kwm_pkg::action_type act, logic [RUN_ID_W-1:0] rid,
                                        logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] pay,
                                        output merge_out_type o);
      slot_type top;
      int src;
      o = '0;
      case (act)
         kwm_pkg::ACT_LOAD: begin
            if (rid >= NRUNS || run_len[rid] >= DEPTH) begin
               o.ovf = 1'b1;
            end else begin
               run_keys[rid][run_len[rid]] = key;
               run_pays[rid][run_len[rid]] = pay;
               run_len[rid]++;
            end
            return 1'b1;
         end
         kwm_pkg::ACT_START: begin
            heap_n = 0;
            for (int j = 0; j < NRUNS; j++) begin
               run_pos[j] = 0;
               if (run_len[j] > 0) begin
                  heap[heap_n] = take_head(j);
                  heap_n++;
                  heap_up(heap_n - 1);
               end
            end
            return 1'b0;
         end
         kwm_pkg::ACT_CLEAR: begin
            for (int j = 0; j < NRUNS; j++) begin
               run_len[j] = 0;
               run_pos[j] = 0;
            end
            heap_n = 0;
            return 1'b0;
         end
         default: begin
            if (heap_n == 0) return 1'b1;
            top = heap[0];
            src = top.run;
            if (run_pos[src] < run_len[src]) begin
               heap[0] = take_head(src);
            end else begin
               heap_n--;
               heap[0] = heap[heap_n];
            end
            heap_down(0);
            o.key  = top.key;
            o.pay  = top.pay;
            o.run  = top.run;
            o.vld  = 1'b1;
            o.last = (heap_n == 0);
            return 1'b1;
         end
      endcase
   endfunction

   // Sender: drives at the falling edge, waits for the handshake at the rising edge.
   task automatic send_request(kwm_pkg::action_type act, logic [RUN_ID_W-1:0] rid,
                               logic [FIELD_W-1:0] key, logic [FIELD_W-1:0] pay,
                               bit has_exp = 1'b0, merge_out_type exp = '0);
      merge_out_type o;
      bit produces;
      req_chan.valid    <= 1'b1;
      req_chan.action   <= act;
      req_chan.run_id   <= rid;
      req_chan.sort_key <= key;
      req_chan.payload  <= pay;
      do @(posedge clock); while (!req_chan.ready);
      produces = merge_predict(act, rid, key, pay, o);
      if (has_exp && o != exp) begin
         $error("directed row mismatch: predictor %p, table %p", o, exp);
         errors++;
      end
      if (produces) expect_result(o);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      // A start may still be sifting after the last result.
      repeat (120) @(negedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] rand_key();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // Receiver: stalls on its own pattern, or for a long stretch when hold_off is set.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) rsp_chan.ready <= 1'b0;
         else if (cycles % 64 < 20) rsp_chan.ready <= 1'b1;
         else rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      merge_out_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.out_key, rsp_chan.out_payload, rsp_chan.out_run,
                 rsp_chan.valid_res, rsp_chan.last, rsp_chan.overflow};
         n_results++;
         if (pending_out.size() == 0) begin
            $error("result with no request pending: %p", got);
            errors++;
         end else begin
            want = pending_out.pop_front();
            if (got.vld) n_valid_pops++;
            if (got.ovf) n_ovf++;
            if (got.key != want.key) begin
               $error("out_key expected %h got %h", want.key, got.key); errors++;
            end
            if (got.pay != want.pay) begin
               $error("out_payload expected %h got %h", want.pay, got.pay); errors++;
            end
            if (got.run != want.run) begin
               $error("out_run expected %0d got %0d", want.run, got.run); errors++;
            end
            if (got.vld != want.vld) begin
               $error("valid_res expected %0b got %0b", want.vld, got.vld); errors++;
            end
            if (got.last != want.last) begin
               $error("last expected %0b got %0b", want.last, got.last); errors++;
            end
            if (got.ovf != want.ovf) begin
               $error("overflow expected %0b got %0b", want.ovf, got.ovf); errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("kway_heap_merge_tb: done, errors");
         $finish;
      end
   end

   initial begin
      merge_out_type z;
      merge_out_type e;
      int nr;
      int sent;
      int burst;
      bit held;

      z = '0;
      held = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.action = kwm_pkg::ACT_LOAD;
      req_chan.run_id = '0;
      req_chan.sort_key = '0;
      req_chan.payload = '0;
      for (int j = 0; j < NRUNS; j++) begin
         run_len[j] = 0;
         run_pos[j] = 0;
      end
      heap_n = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: empty pop after reset, load results, extremes, equal keys.
      add_row(kwm_pkg::ACT_POP,   4'd0,  32'h0, 32'h0, 1'b1, z);
      add_row(kwm_pkg::ACT_START, 4'd0,  32'h0, 32'h0, 1'b0, z);
      add_row(kwm_pkg::ACT_POP,   4'd0,  32'h0, 32'h0, 1'b1, z);
      add_row(kwm_pkg::ACT_LOAD,  4'd0,  32'h0, 32'hFFFFFFFF, 1'b1, z);
      add_row(kwm_pkg::ACT_LOAD,  4'd15, 32'hFFFFFFFF, 32'h0, 1'b1, z);
      add_row(kwm_pkg::ACT_LOAD,  4'd15, 32'hFFFFFFFF, 32'h5A5A5A5A, 1'b1, z);
      add_row(kwm_pkg::ACT_LOAD,  4'd3,  32'h00000010, 32'hA5A5A5A5, 1'b1, z);
      add_row(kwm_pkg::ACT_LOAD,  4'd7,  32'h00000010, 32'h12345678, 1'b1, z);
      add_row(kwm_pkg::ACT_LOAD,  4'd3,  32'h80000000, 32'h1, 1'b1, z);
      add_row(kwm_pkg::ACT_START, 4'd0,  32'h0, 32'h0, 1'b0, z);
      e = '{32'h0, 32'hFFFFFFFF, 4'd0, 1'b1, 1'b0, 1'b0};
      add_row(kwm_pkg::ACT_POP,   4'd0,  32'h0, 32'h0, 1'b1, e);
      add_row(kwm_pkg::ACT_POP,   4'd0,  32'h0, 32'h0, 1'b0, z);
      // Load during the merge into a run still in the heap.
      add_row(kwm_pkg::ACT_LOAD,  4'd7,  32'h00000011, 32'h77, 1'b1, z);
      for (int i = 0; i < 6; i++)
         add_row(kwm_pkg::ACT_POP, 4'd0, 32'h0, 32'h0, 1'b0, z);
      add_row(kwm_pkg::ACT_POP,   4'd0,  32'h0, 32'h0, 1'b1, z);
      add_row(kwm_pkg::ACT_CLEAR, 4'd0,  32'h0, 32'h0, 1'b0, z);
      add_row(kwm_pkg::ACT_START, 4'd0,  32'h0, 32'h0, 1'b0, z);
      add_row(kwm_pkg::ACT_POP,   4'd0,  32'h0, 32'h0, 1'b1, z);

      foreach (rows[i])
         send_request(rows[i].act, rows[i].rid, rows[i].key, rows[i].pay,
                      rows[i].has_exp, rows[i].exp);
      drain_results();

      // Fill one run to its depth, then a load into it must overflow.
      for (int i = 0; i < DEPTH; i++)
         send_request(kwm_pkg::ACT_LOAD, 4'd9, 32'(i), $urandom());
      e = '0; e.ovf = 1'b1;
      send_request(kwm_pkg::ACT_LOAD, 4'd9, 32'h1, 32'h2, 1'b1, e);
      send_request(kwm_pkg::ACT_CLEAR, 4'd0, 32'h0, 32'h0);
      drain_results();

      // Random merge passes: clear, load runs with random keys, start, pop with noise mixed in.
      sent = 0;
      while (sent < 550) begin
         send_request(kwm_pkg::ACT_CLEAR, 4'd0, 32'h0, 32'h0);
         nr = $urandom_range(4, 40);
         for (int i = 0; i < nr; i++) begin
            send_request(kwm_pkg::ACT_LOAD, 4'($urandom_range(0, 15)), rand_key(),
                         $urandom());
            sent++;
            burst = $urandom_range(0, 7);
            if (burst == 0) idle_gap();
         end
         send_request(kwm_pkg::ACT_START, 4'd0, 32'h0, 32'h0);
         for (int i = 0; i < nr + 2; i++) begin
            case ($urandom_range(0, 11))
               0: send_request(kwm_pkg::ACT_LOAD, 4'($urandom_range(0, 15)), rand_key(),
                               $urandom());
               1: send_request(kwm_pkg::ACT_START, 4'd0, 32'h0, 32'h0);
               default: send_request(kwm_pkg::ACT_POP, 4'($urandom()), $urandom(),
                                     $urandom());
            endcase
            sent++;
            if ($urandom_range(0, 5) == 0) idle_gap();
         end
         // Once in the run the receiver holds off while requests keep coming.
         if (sent > 250 && !held) begin
            held = 1'b1;
            hold_off = 1'b1;
            fork
               begin
                  repeat (300) @(negedge clock);
                  hold_off = 1'b0;
               end
               begin
                  for (int i = 0; i < 30; i++)
                     send_request(kwm_pkg::ACT_LOAD, 4'($urandom_range(0, 15)),
                                  rand_key(), $urandom());
               end
            join
            sent += 30;
         end
         if ($urandom_range(0, 3) == 0) drain_results();
      end

      drain_results();
      $display("covered %0d result checks, %0d merged elements, %0d dropped loads",
               n_results, n_valid_pops, n_ovf);
      if (errors == 0)
         $display("kway_heap_merge_tb: done, clean");
      else
         $display("kway_heap_merge_tb: done, errors");
      $finish;
   end

endmodule
